/* design/tcgr_pkg.sv */
// Shared types, codes and helper functions of the text cell glyph renderer.
`timescale 1ns / 1ps
package tcgr_pkg;

   // Request opcodes (code 3 is reserved and dropped)
   localparam logic [1:0] OP_WRITE_GLYPH = 2'd0;
   localparam logic [1:0] OP_DRAW_CHAR   = 2'd1;
   localparam logic [1:0] OP_READ_CELL   = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_GLYPH_WIDTH     = 2'd0;
   localparam logic [1:0] CSR_GLYPH_HEIGHT    = 2'd1;
   localparam logic [1:0] CSR_COLUMNS_PER_ROW = 2'd2;

   // Result kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_CELL  = 1'b1;

   // Glyph size limits and register reset values
   localparam logic [3:0] GLYPH_DIM_MIN      = 4'd1;
   localparam logic [3:0] GLYPH_DIM_MAX      = 4'd8;
   localparam logic [3:0] GLYPH_WIDTH_RESET  = 4'd8;
   localparam logic [3:0] GLYPH_HEIGHT_RESET = 4'd8;
   localparam logic [7:0] COLUMNS_RESET      = 8'd80;

   // Widest intermediate values
   localparam int CELL_LIN_W  = 14;  // row*columns + column
   localparam int GLYPH_BIT_W = 14;  // code*w*h + py*w + px
   localparam int CELL_LIN_MAX = 16383;
   localparam int GLYPH_BYTE_MAX = 2047;
   localparam int CODE_MAX = 255;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [10:0] glyph_byte_address;
      logic [7:0]  glyph_byte_data;
      logic [6:0]  cell_column;
      logic [5:0]  cell_row;
      logic [7:0]  char_code;
      logic [7:0]  fg_red;
      logic [7:0]  fg_green;
      logic [7:0]  fg_blue;
   } req_payload_type;

   typedef struct packed {
      logic        result_kind;
      logic [9:0]  pixel_x;
      logic [9:0]  pixel_y;
      logic [7:0]  out_code;
      logic [7:0]  out_red;
      logic [7:0]  out_green;
      logic [7:0]  out_blue;
      logic        last_of_run;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_step;
      logic glyph_write;
      logic capture;
      logic prep_lin;
      logic prep_red;
      logic cell_write;
      logic draw_start;
      logic cell_issue;
      logic pix_issue;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done;
      logic slot_free;
      logic last_pix;
   } status_type;

   // Zero counts as one, anything above eight as eight
   function automatic logic [3:0] clamp_dim(input logic [3:0] v);
      logic [3:0] r;
      r = v;
      if (v < GLYPH_DIM_MIN) r = GLYPH_DIM_MIN;
      else if (v > GLYPH_DIM_MAX) r = GLYPH_DIM_MAX;
      return r;
   endfunction

endpackage

/* design/tcgr_req_if.sv */
// Request channel interface of the text cell glyph renderer.
`timescale 1ns / 1ps
interface tcgr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [10:0] glyph_byte_address;
   logic [7:0]  glyph_byte_data;
   logic [6:0]  cell_column;
   logic [5:0]  cell_row;
   logic [7:0]  char_code;
   logic [7:0]  fg_red;
   logic [7:0]  fg_green;
   logic [7:0]  fg_blue;

   modport source (
      output valid, opcode, glyph_byte_address, glyph_byte_data, cell_column,
             cell_row, char_code, fg_red, fg_green, fg_blue,
      input  ready
   );
   modport sink (
      input  valid, opcode, glyph_byte_address, glyph_byte_data, cell_column,
             cell_row, char_code, fg_red, fg_green, fg_blue,
      output ready
   );
endinterface

/* design/tcgr_rsp_if.sv */
// Result channel interface of the text cell glyph renderer.
`timescale 1ns / 1ps
interface tcgr_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [9:0] pixel_x;
   logic [9:0] pixel_y;
   logic [7:0] out_code;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       last_of_run;

   modport source (
      output valid, result_kind, pixel_x, pixel_y, out_code, out_red,
             out_green, out_blue, last_of_run,
      input  ready
   );
   modport sink (
      input  valid, result_kind, pixel_x, pixel_y, out_code, out_red,
             out_green, out_blue, last_of_run,
      output ready
   );
endinterface

/* design/tcgr_csr_if.sv */
// Configuration write channel interface of the text cell glyph renderer.
`timescale 1ns / 1ps
interface tcgr_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

/* design/tcgr_ctrl.sv */
// Controller state machine of the text cell glyph renderer.
`timescale 1ns / 1ps
module tcgr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_opcode,
   output logic                 req_ready,
   input  tcgr_pkg::status_type status,
   output tcgr_pkg::cmd_type    cmd
);
   import tcgr_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_LIN   = 6'b000100,
      ST_RED   = 6'b001000,
      ST_SETUP = 6'b010000,
      ST_DRAW  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      is_draw_ff, is_draw_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Sequence one request at a time
   always_comb begin
      state_in   = state_ff;
      is_draw_in = is_draw_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  OP_WRITE_GLYPH: cmd.glyph_write = 1'b1;
                  OP_DRAW_CHAR: begin
                     cmd.capture = 1'b1;
                     is_draw_in  = 1'b1;
                     state_in    = ST_LIN;
                  end
                  OP_READ_CELL: begin
                     cmd.capture = 1'b1;
                     is_draw_in  = 1'b0;
                     state_in    = ST_LIN;
                  end
                  default: begin
                     // reserved opcode: drop the beat
                  end
               endcase
            end
         end
         ST_LIN: begin
            cmd.prep_lin = 1'b1;
            state_in     = ST_RED;
         end
         ST_RED: begin
            cmd.prep_red = 1'b1;
            state_in     = ST_SETUP;
         end
         ST_SETUP: begin
            if (is_draw_ff) begin
               cmd.cell_write = 1'b1;
               cmd.draw_start = 1'b1;
               state_in       = ST_DRAW;
            end else if (status.slot_free) begin
               cmd.cell_issue = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_DRAW: begin
            if (status.slot_free) begin
               cmd.pix_issue = 1'b1;
               if (status.last_pix) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         is_draw_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         is_draw_ff <= is_draw_in;
      end
   end

endmodule

/* design/tcgr_datapath.sv */
// Datapath of the text cell glyph renderer: stores, address math, pixel pipeline.
`timescale 1ns / 1ps
module tcgr_datapath #(
   parameter int GLYPH_MEMORY_BYTES = 2048,
   parameter int CELL_STORE_DEPTH   = 8192,
   parameter int GLYPH_COUNT        = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tcgr_pkg::cmd_type         cmd,
   output tcgr_pkg::status_type      status,
   input  tcgr_pkg::req_payload_type req,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [7:0]                csr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tcgr_pkg::rsp_payload_type rsp
);
   import tcgr_pkg::*;

   localparam int GA_W  = $clog2(GLYPH_MEMORY_BYTES);
   localparam int GA_W1 = GA_W + 1;
   localparam int CA_W  = $clog2(CELL_STORE_DEPTH);
   // Conditional-subtract steps needed for each modulo reduction
   localparam int CODE_STEPS = $clog2(CODE_MAX / GLYPH_COUNT + 1);
   localparam int CELL_STEPS = $clog2(CELL_LIN_MAX / CELL_STORE_DEPTH + 1);
   localparam int BYTE_STEPS = $clog2(GLYPH_BYTE_MAX / GLYPH_MEMORY_BYTES + 1);

   // Reduce v modulo m by subtracting m shifted down from the top, at most 8 steps
   function automatic logic [15:0] mod_sub(input logic [15:0] v, input int m,
                                           input int steps);
      logic [15:0] r;
      r = v;
      for (int k = 7; k >= 0; k--) begin
         if (k < steps) begin
            if (32'(r) >= (m << k)) r = r - 16'(m << k);
         end
      end
      return r;
   endfunction

   // Next glyph byte address, wrapping at the memory size
   function automatic logic [GA_W-1:0] inc_wrap(input logic [GA_W-1:0] b);
      logic [GA_W1-1:0] s;
      s = {1'b0, b} + GA_W1'(1);
      if (s == GA_W1'(GLYPH_MEMORY_BYTES)) s = '0;
      return s[GA_W-1:0];
   endfunction

   // Stores
   logic [7:0]  glyph_mem [GLYPH_MEMORY_BYTES];
   logic [31:0] cell_mem  [CELL_STORE_DEPTH];

   // Configuration
   logic [3:0] glyph_width_ff, glyph_height_ff;
   logic [7:0] columns_ff;
   logic [3:0] w_eff, h_eff;

   // Captured request
   logic [6:0] col_ff;
   logic [5:0] row_ff;
   logic [7:0] code_ff, red_ff, green_ff, blue_ff;

   // Address preparation
   logic [CELL_LIN_W-1:0]  lin_ff;
   logic [7:0]             code_red_ff;
   logic [6:0]             wh_ff;
   logic [9:0]             xbase_ff, ybase_ff;
   logic [CA_W-1:0]        cell_addr_ff;
   logic [GLYPH_BIT_W-1:0] base_bit_ff;
   logic [GA_W-1:0]        base_byte;

   // Pixel walk
   logic [GA_W-1:0] byte_ff, col_byte_ff;
   logic [2:0]      off_ff, col_off_ff;
   logic [2:0]      px_ff, py_ff;
   logic [9:0]      x_ff, y_ff;
   logic [3:0]      off_sum, col_off_sum;
   logic            col_last;

   // Clearing pass
   logic [CA_W-1:0] clr_ff;

   // Read data and pipeline stage
   logic [7:0]  glyph_q_ff;
   logic [31:0] cell_q_ff;
   logic        s1_valid_ff, s1_kind_ff, s1_last_ff;
   logic [9:0]  s1_x_ff, s1_y_ff;
   logic [2:0]  s1_off_ff;
   logic [7:0]  s1_red_ff, s1_green_ff, s1_blue_ff;
   logic        s1_move, s1_bit;

   // Output register
   logic            out_valid_ff;
   rsp_payload_type out_ff, out_in;

   assign w_eff = clamp_dim(glyph_width_ff);
   assign h_eff = clamp_dim(glyph_height_ff);

   assign col_last    = ({1'b0, py_ff} == h_eff - 4'd1);
   assign off_sum     = {1'b0, off_ff} + w_eff;
   assign col_off_sum = {1'b0, col_off_ff} + 4'd1;
   assign base_byte   = GA_W'(mod_sub(16'(base_bit_ff[GLYPH_BIT_W-1:3]),
                                      GLYPH_MEMORY_BYTES, BYTE_STEPS));

   assign s1_move = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign s1_bit  = glyph_q_ff[~s1_off_ff];

   assign status.clear_done = (clr_ff == CA_W'(CELL_STORE_DEPTH - 1));
   assign status.slot_free  = !s1_valid_ff || s1_move;
   assign status.last_pix   = col_last && ({1'b0, px_ff} == w_eff - 4'd1);

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_width_ff  <= GLYPH_WIDTH_RESET;
         glyph_height_ff <= GLYPH_HEIGHT_RESET;
         columns_ff      <= COLUMNS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GLYPH_WIDTH:     glyph_width_ff  <= csr_data[3:0];
            CSR_GLYPH_HEIGHT:    glyph_height_ff <= csr_data[3:0];
            CSR_COLUMNS_PER_ROW: columns_ff      <= csr_data;
            default: begin
               // unmapped index: ignore the beat
            end
         endcase
      end
   end

   // Glyph memory: byte writes, one registered read per pixel
   always_ff @(posedge clock) begin
      if (cmd.glyph_write && (32'(req.glyph_byte_address) < GLYPH_MEMORY_BYTES)) begin
         glyph_mem[GA_W'(req.glyph_byte_address)] <= req.glyph_byte_data;
      end
      if (cmd.pix_issue) glyph_q_ff <= glyph_mem[byte_ff];
   end

   // Cell store: clearing pass, cell writes, registered read
   always_ff @(posedge clock) begin
      if (cmd.clear_step) cell_mem[clr_ff] <= '0;
      else if (cmd.cell_write) cell_mem[cell_addr_ff] <= {code_ff, red_ff, green_ff, blue_ff};
      if (cmd.cell_issue) cell_q_ff <= cell_mem[cell_addr_ff];
   end

   // Advance the clearing address
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_ff + CA_W'(1);
   end

   // Capture the request and prepare addresses
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         col_ff   <= req.cell_column;
         row_ff   <= req.cell_row;
         code_ff  <= req.char_code;
         red_ff   <= req.fg_red;
         green_ff <= req.fg_green;
         blue_ff  <= req.fg_blue;
      end
      if (cmd.prep_lin) begin
         lin_ff      <= CELL_LIN_W'(row_ff) * CELL_LIN_W'(columns_ff) + CELL_LIN_W'(col_ff);
         code_red_ff <= 8'(mod_sub(16'(code_ff), GLYPH_COUNT, CODE_STEPS));
         wh_ff       <= 7'(w_eff) * 7'(h_eff);
         xbase_ff    <= 10'(col_ff) * 10'(w_eff);
         ybase_ff    <= 10'(row_ff) * 10'(h_eff);
      end
      if (cmd.prep_red) begin
         cell_addr_ff <= CA_W'(mod_sub(16'(lin_ff), CELL_STORE_DEPTH, CELL_STEPS));
         base_bit_ff  <= GLYPH_BIT_W'(code_red_ff) * GLYPH_BIT_W'(wh_ff);
      end
   end

   // Walk the glyph column by column, one pixel per issue
   always_ff @(posedge clock) begin
      if (cmd.draw_start) begin
         byte_ff     <= base_byte;
         col_byte_ff <= base_byte;
         off_ff      <= base_bit_ff[2:0];
         col_off_ff  <= base_bit_ff[2:0];
         px_ff       <= '0;
         py_ff       <= '0;
         x_ff        <= xbase_ff;
         y_ff        <= ybase_ff;
      end else if (cmd.pix_issue) begin
         if (col_last) begin
            // next column starts one bit after the previous column start
            col_off_ff <= col_off_sum[2:0];
            off_ff     <= col_off_sum[2:0];
            if (col_off_sum[3]) begin
               col_byte_ff <= inc_wrap(col_byte_ff);
               byte_ff     <= inc_wrap(col_byte_ff);
            end else begin
               byte_ff <= col_byte_ff;
            end
            px_ff <= px_ff + 3'd1;
            py_ff <= '0;
            x_ff  <= x_ff + 10'd1;
            y_ff  <= ybase_ff;
         end else begin
            // next row is one glyph width further on
            off_ff <= off_sum[2:0];
            if (off_sum[3]) byte_ff <= inc_wrap(byte_ff);
            py_ff <= py_ff + 3'd1;
            y_ff  <= y_ff + 10'd1;
         end
      end
   end

   // Stage one: holds the beat while its read data arrives
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (cmd.pix_issue || cmd.cell_issue) s1_valid_ff <= 1'b1;
      else if (s1_move) s1_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.pix_issue) begin
         s1_kind_ff  <= KIND_PIXEL;
         s1_x_ff     <= x_ff;
         s1_y_ff     <= y_ff;
         s1_off_ff   <= off_ff;
         s1_red_ff   <= red_ff;
         s1_green_ff <= green_ff;
         s1_blue_ff  <= blue_ff;
         s1_last_ff  <= status.last_pix;
      end else if (cmd.cell_issue) begin
         s1_kind_ff <= KIND_CELL;
         s1_last_ff <= 1'b1;
      end
   end

   // Form the result beat
   always_comb begin
      out_in = '0;
      if (s1_kind_ff == KIND_CELL) begin
         out_in.result_kind = KIND_CELL;
         out_in.out_code    = cell_q_ff[31:24];
         out_in.out_red     = cell_q_ff[23:16];
         out_in.out_green   = cell_q_ff[15:8];
         out_in.out_blue    = cell_q_ff[7:0];
         out_in.last_of_run = 1'b1;
      end else begin
         out_in.result_kind = KIND_PIXEL;
         out_in.pixel_x     = s1_x_ff;
         out_in.pixel_y     = s1_y_ff;
         out_in.out_red     = s1_bit ? s1_red_ff : 8'd0;
         out_in.out_green   = s1_bit ? s1_green_ff : 8'd0;
         out_in.out_blue    = s1_bit ? s1_blue_ff : 8'd0;
         out_in.last_of_run = s1_last_ff;
      end
   end

   // Output register: load from stage one, drop when taken
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (s1_move) out_valid_ff <= 1'b1;
      else if (rsp_ready) out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (s1_move) out_ff <= out_in;
   end

endmodule

/* design/text_cell_glyph_renderer_top.sv */
// Top level of the text cell glyph renderer.
// Usage:
//   req_bus carries commands: write one glyph memory byte, draw a character
//   cell, or read a stored cell back. A beat moves on valid and ready high.
//   rsp_bus returns result beats: w*h pixels per draw in column-major order,
//   black where the glyph bit is clear, last_of_run on the final pixel; one
//   beat per cell read. Glyph writes and the reserved opcode return nothing.
//   csr_bus writes glyph width, glyph height and columns per row; it is
//   always ready and must only be used while no request is in flight.
// Sequencing:
//   A glyph write is taken in idle. A draw or read is accepted, then passes
//   through the states LIN and RED, which prepare the cell index and glyph
//   bit offset, and SETUP; the pixel walk then issues one glyph memory read
//   per cycle while stage one has a free slot. The single glyph memory read
//   port sets the pixel rate.
// Reset and stall:
//   After reset the cell store is zeroed, one entry per cycle, over all
//   CELL_STORE_DEPTH entries; req_bus.ready stays low during that pass.
//   When the receiver stalls, the output register and one pipeline stage
//   hold their beats and the pixel walk pauses without loss.
`timescale 1ns / 1ps
module text_cell_glyph_renderer_top #(
   parameter int GLYPH_MEMORY_BYTES = 2048,
   parameter int CELL_STORE_DEPTH   = 8192,
   parameter int GLYPH_COUNT        = 256
) (
   input  logic         clock,
   input  logic         reset,
   tcgr_req_if.sink     req_bus,
   tcgr_rsp_if.source   rsp_bus,
   tcgr_csr_if.sink     csr_bus
);
   import tcgr_pkg::*;

   cmd_type         cmd;
   status_type      status;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;

   // Pack the request beat
   assign req_payload.opcode             = req_bus.opcode;
   assign req_payload.glyph_byte_address = req_bus.glyph_byte_address;
   assign req_payload.glyph_byte_data    = req_bus.glyph_byte_data;
   assign req_payload.cell_column        = req_bus.cell_column;
   assign req_payload.cell_row           = req_bus.cell_row;
   assign req_payload.char_code          = req_bus.char_code;
   assign req_payload.fg_red             = req_bus.fg_red;
   assign req_payload.fg_green           = req_bus.fg_green;
   assign req_payload.fg_blue            = req_bus.fg_blue;

   // Configuration writes land at once
   assign csr_bus.ready = 1'b1;

   tcgr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .req_ready  (req_bus.ready),
      .status     (status),
      .cmd        (cmd)
   );

   tcgr_datapath #(
      .GLYPH_MEMORY_BYTES (GLYPH_MEMORY_BYTES),
      .CELL_STORE_DEPTH   (CELL_STORE_DEPTH),
      .GLYPH_COUNT        (GLYPH_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req       (req_payload),
      .csr_we    (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp       (rsp_payload)
   );

   // Unpack the result beat
   assign rsp_bus.result_kind = rsp_payload.result_kind;
   assign rsp_bus.pixel_x     = rsp_payload.pixel_x;
   assign rsp_bus.pixel_y     = rsp_payload.pixel_y;
   assign rsp_bus.out_code    = rsp_payload.out_code;
   assign rsp_bus.out_red     = rsp_payload.out_red;
   assign rsp_bus.out_green   = rsp_payload.out_green;
   assign rsp_bus.out_blue    = rsp_payload.out_blue;
   assign rsp_bus.last_of_run = rsp_payload.last_of_run;

   // No request is taken in the cycle after reset: the clearing pass runs
   a_clear_blocks_req: assert property (@(posedge clock)
      reset |=> !req_bus.ready)
      else $error("request accepted during cell store clearing pass");

   // Pipeline issues only go out when stage one can take them
   a_issue_has_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.pix_issue || cmd.cell_issue) |-> status.slot_free)
      else $error("pixel or cell issue without a free pipeline slot");

   // The glyph memory port is never asked to write and read at once
   a_glyph_port: assert property (@(posedge clock) disable iff (reset)
      !(cmd.glyph_write && cmd.pix_issue))
      else $error("glyph memory write and read collide");

   // The clearing pass owns the cell store alone
   a_cell_port: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !(cmd.cell_write || cmd.cell_issue || req_bus.ready))
      else $error("cell store access during clearing pass");

endmodule
